// ----- rtl/core/lmsn_pkg.sv -----
// Shared constants and types of the local mean subtract and normalise block.
// No dependencies; used by lmsn_div and local_mean_subtract_normalize.
package lmsn_pkg;

   localparam int WIDTH  = 96;
   localparam int HEIGHT = 96;
   localparam int RADIUS = 4;

   localparam int COL_W  = 7;
   localparam int ROW_W  = 7;
   localparam int PIX_W  = 8;

   localparam int XW     = (WIDTH  > 1) ? $clog2(WIDTH)  : 1;
   localparam int YW     = (HEIGHT > 1) ? $clog2(HEIGHT) : 1;
   localparam int DEPTH  = WIDTH * HEIGHT;
   localparam int AW     = $clog2(DEPTH);

   localparam int SIDE   = 2 * RADIUS + 1;
   localparam int SPW    = $clog2(SIDE + 1);
   localparam int CNT_W  = $clog2(SIDE * SIDE + 1);
   localparam int SUM_W  = $clog2(255 * SIDE * SIDE + 1);
   localparam int CI_W   = 10;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_READ  = 1'b1;

   typedef struct packed {
      logic             start;
      logic [SUM_W-1:0] dividend;
      logic [CNT_W-1:0] divisor;
   } div_req_type;

endpackage

// ----- rtl/core/local_mean_subtract_normalize.sv -----
// Top level: pixel store, window walk, mean division and normalised output.
// Depends on lmsn_pkg, lmsn_ram and lmsn_div.
//
//   channel  direction  handshake               payload
//   req      in         req_tvalid/req_tready   tuser: func; tdata: col, row, pixel_in
//   rsp      out        rsp_tvalid/rsp_tready   tdata: norm_value
//
// A write goes to the store as it is accepted. A read walks the clipped window
// at one store read a cycle, then the divider forms the window mean from the
// window sum and area; no new request is taken until the result is registered.
// Synchronous active-high reset clears control; the store is undefined until written.
// A held result register lets the next item be accepted while a result waits.
module local_mean_subtract_normalize (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // col[6:0], row[13:7], pixel_in[21:14], zero fill
   input  logic [0:0]  req_tuser,   // func[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // norm_value[7:0]
);

   localparam int WIDTH  = lmsn_pkg::WIDTH;
   localparam int HEIGHT = lmsn_pkg::HEIGHT;
   localparam int RADIUS = lmsn_pkg::RADIUS;
   localparam int XW     = lmsn_pkg::XW;
   localparam int YW     = lmsn_pkg::YW;
   localparam int AW     = lmsn_pkg::AW;
   localparam int SPW    = lmsn_pkg::SPW;
   localparam int CNT_W  = lmsn_pkg::CNT_W;
   localparam int SUM_W  = lmsn_pkg::SUM_W;
   localparam int CI_W   = lmsn_pkg::CI_W;
   localparam int PIX_W  = lmsn_pkg::PIX_W;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_WALK   = 3'd1;
   localparam logic [2:0] ST_DRAIN  = 3'd2;
   localparam logic [2:0] ST_LAUNCH = 3'd3;
   localparam logic [2:0] ST_WAIT   = 3'd4;
   localparam logic [2:0] ST_FINISH = 3'd5;

   logic [2:0]       state_ff, state_in;
   logic [XW-1:0]    wx_ff, wx_in, x0_ff, x0_in, x1_ff, x1_in;
   logic [YW-1:0]    wy_ff, wy_in, y1_ff, y1_in;
   logic [AW-1:0]    base_ff, base_in, ctr_ff, ctr_in;
   logic [SPW-1:0]   spx_ff, spx_in, spy_ff, spy_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [PIX_W-1:0] pix_ff, pix_in;
   logic [PIX_W-1:0] mean_ff, mean_in;
   logic             rdv_ff, rdv_in, isc_ff, isc_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_data_ff, rsp_data_in;

   logic [6:0]       col, row;
   logic [PIX_W-1:0] pixel_in;
   logic             func, accept, in_range;
   logic [CI_W-1:0]  cx, cy, x0c, x1c, y0c, y1c, x1t, y1t;
   logic [AW-1:0]    req_addr, walk_addr, ram_addr;
   logic             ram_we;
   logic [PIX_W-1:0] ram_rdata;
   logic             issue;
   logic signed [PIX_W+1:0] v;

   lmsn_pkg::div_req_type div_req;
   logic                  div_done;
   logic [SUM_W-1:0]      div_quo;

   assign col      = req_tdata[6:0];
   assign row      = req_tdata[13:7];
   assign pixel_in = req_tdata[21:14];
   assign func     = req_tuser[0];

   assign req_tready = (state_ff == ST_IDLE) && !reset;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      cx  = CI_W'(col);
      cy  = CI_W'(row);
      in_range = (cx < CI_W'(WIDTH)) && (cy < CI_W'(HEIGHT));
      x0c = (cx >= CI_W'(RADIUS)) ? cx - CI_W'(RADIUS) : '0;
      y0c = (cy >= CI_W'(RADIUS)) ? cy - CI_W'(RADIUS) : '0;
      x1t = cx + CI_W'(RADIUS);
      y1t = cy + CI_W'(RADIUS);
      x1c = (x1t > CI_W'(WIDTH - 1))  ? CI_W'(WIDTH - 1)  : x1t;
      y1c = (y1t > CI_W'(HEIGHT - 1)) ? CI_W'(HEIGHT - 1) : y1t;
      req_addr  = AW'(cy[YW-1:0] * AW'(WIDTH)) + AW'(cx[XW-1:0]);
      walk_addr = base_ff + AW'(wx_ff);
   end

   assign issue    = (state_ff == ST_WALK);
   assign ram_we   = accept && in_range && (func == lmsn_pkg::FUNC_WRITE);
   assign ram_addr = issue ? walk_addr : req_addr;

   lmsn_ram #(
      .DATA_W (PIX_W),
      .DEPTH  (lmsn_pkg::DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (pixel_in),
      .rdata (ram_rdata)
   );

   lmsn_div u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      div_req.start    = (state_ff == ST_LAUNCH);
      div_req.dividend = sum_ff;
      div_req.divisor  = CNT_W'(spx_ff * spy_ff);
   end

   always_comb begin
      state_in     = state_ff;
      wx_in        = wx_ff;
      wy_in        = wy_ff;
      x0_in        = x0_ff;
      x1_in        = x1_ff;
      y1_in        = y1_ff;
      base_in      = base_ff;
      ctr_in       = ctr_ff;
      spx_in       = spx_ff;
      spy_in       = spy_ff;
      sum_in       = sum_ff;
      pix_in       = pix_ff;
      mean_in      = mean_ff;
      rdv_in       = issue;
      isc_in       = issue && (walk_addr == ctr_ff);
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      v = $signed({2'b00, pix_ff}) - $signed({2'b00, mean_ff}) + $signed(10'sd128);

      if (rdv_ff) begin
         sum_in = sum_ff + SUM_W'(ram_rdata);
         if (isc_ff) begin
            pix_in = ram_rdata;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && in_range && (func == lmsn_pkg::FUNC_READ)) begin
               x0_in   = x0c[XW-1:0];
               x1_in   = x1c[XW-1:0];
               y1_in   = y1c[YW-1:0];
               wx_in   = x0c[XW-1:0];
               wy_in   = y0c[YW-1:0];
               base_in = AW'(y0c[YW-1:0] * AW'(WIDTH));
               ctr_in  = req_addr;
               spx_in  = SPW'(x1c - x0c + 1'b1);
               spy_in  = SPW'(y1c - y0c + 1'b1);
               sum_in  = '0;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (wx_ff == x1_ff) begin
               wx_in   = x0_ff;
               wy_in   = wy_ff + 1'b1;
               base_in = base_ff + AW'(WIDTH);
               if (wy_ff == y1_ff) begin
                  state_in = ST_DRAIN;
               end
            end else begin
               wx_in = wx_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_LAUNCH;
         end
         ST_LAUNCH: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (div_done) begin
               mean_in  = div_quo[PIX_W-1:0];
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               if (v < 0) begin
                  rsp_data_in = 8'd0;
               end else if (v > 10'sd255) begin
                  rsp_data_in = 8'd255;
               end else begin
                  rsp_data_in = v[7:0];
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rdv_ff       <= 1'b0;
         isc_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rdv_ff       <= rdv_in;
         isc_ff       <= isc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      wx_ff       <= wx_in;
      wy_ff       <= wy_in;
      x0_ff       <= x0_in;
      x1_ff       <= x1_in;
      y1_ff       <= y1_in;
      base_ff     <= base_in;
      ctr_ff      <= ctr_in;
      spx_ff      <= spx_in;
      spy_ff      <= spy_in;
      sum_ff      <= sum_in;
      pix_ff      <= pix_in;
      mean_ff     <= mean_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- rtl/core/lmsn_ram.sv -----
// Generic single-port synchronous RAM, registered read: data appears in the cycle after the address.
// No dependencies.
module lmsn_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [DATA_W-1:0]        wdata,
   output logic [DATA_W-1:0]        rdata
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/core/lmsn_div.sv -----
// Restoring divider, one quotient bit per cycle, for the window mean.
// Depends on lmsn_pkg.
module lmsn_div (
   input  logic                        clock,
   input  logic                        reset,
   input  lmsn_pkg::div_req_type       req,
   output logic                        done,
   output logic [lmsn_pkg::SUM_W-1:0]  quotient
);

   localparam int SUM_W = lmsn_pkg::SUM_W;
   localparam int CNT_W = lmsn_pkg::CNT_W;
   localparam int IT_W  = $clog2(SUM_W + 1);

   logic [SUM_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] dvs_ff, dvs_in;
   logic [IT_W-1:0]  it_ff, it_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W:0]   partial;
   logic [CNT_W+1:0] diff;

   always_comb begin
      partial = {rem_ff, quo_ff[SUM_W-1]};
      diff    = {1'b0, partial} - {2'b00, dvs_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      it_in   = it_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         quo_in  = req.dividend;
         rem_in  = '0;
         dvs_in  = req.divisor;
         it_in   = IT_W'(SUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[CNT_W+1]) begin
            rem_in = diff[CNT_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_in = partial[CNT_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b0};
         end
         it_in = it_ff - 1'b1;
         if (it_ff == IT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      it_ff  <= it_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- verif/local_mean_subtract_normalize_checker.sv -----
// Checker for local_mean_subtract_normalize: watches the req and rsp streams,
// keeps its own copy of the pixel store and predicts each normalised pixel.
// Depends on lmsn_pkg; hands failure and pending counts to the testbench top.
`timescale 1ns / 1ps

module local_mean_subtract_normalize_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,   // col[6:0], row[13:7], pixel_in[21:14], zero fill
   input  logic [0:0]  req_tuser,   // func[0]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,   // norm_value[7:0]
   output int          fail_count,
   output int          pending_count,
   output int          checked_count
);

   localparam int WIDTH  = lmsn_pkg::WIDTH;
   localparam int HEIGHT = lmsn_pkg::HEIGHT;
   localparam int RADIUS = lmsn_pkg::RADIUS;
   localparam int DEPTH  = lmsn_pkg::DEPTH;
   localparam int COL_W  = lmsn_pkg::COL_W;
   localparam int ROW_W  = lmsn_pkg::ROW_W;
   localparam int PIX_W  = lmsn_pkg::PIX_W;

   logic [PIX_W-1:0] frame_copy [DEPTH];
   logic [PIX_W-1:0] expected_norm [$];

   initial begin
      fail_count    = 0;
      pending_count = 0;
      checked_count = 0;
   end

   // pixel minus floor of clipped window mean, plus 128, saturated
   function automatic logic [PIX_W-1:0] normalised_pixel(input int x, input int y);
      int x0, x1, y0, y1;
      int unsigned total, area;
      int v;
      x0 = (x - RADIUS < 0) ? 0 : x - RADIUS;
      x1 = (x + RADIUS > WIDTH - 1) ? WIDTH - 1 : x + RADIUS;
      y0 = (y - RADIUS < 0) ? 0 : y - RADIUS;
      y1 = (y + RADIUS > HEIGHT - 1) ? HEIGHT - 1 : y + RADIUS;
      total = 0;
      for (int j = y0; j <= y1; j++)
         for (int i = x0; i <= x1; i++)
            total += frame_copy[j * WIDTH + i];
      area = (x1 - x0 + 1) * (y1 - y0 + 1);
      v = int'(frame_copy[y * WIDTH + x]) - int'(total / area) + 128;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return PIX_W'(v);
   endfunction

   task automatic take_request(input logic func, input logic [23:0] data);
      int c, r;
      logic [PIX_W-1:0] p;
      c = int'(data[COL_W-1:0]);
      r = int'(data[COL_W +: ROW_W]);
      p = data[COL_W+ROW_W +: PIX_W];
      if (c < WIDTH && r < HEIGHT) begin
         if (func == lmsn_pkg::FUNC_WRITE) begin
            frame_copy[r * WIDTH + c] = p;
         end else begin
            expected_norm.push_back(normalised_pixel(c, r));
            pending_count++;
         end
      end
   endtask

   task automatic check_result(input logic [PIX_W-1:0] got);
      logic [PIX_W-1:0] want;
      if (expected_norm.size() == 0) begin
         fail_count++;
         if (fail_count <= 10)
            $display("%0t: result %0d with no item outstanding", $realtime, got);
      end else begin
         want = expected_norm.pop_front();
         pending_count--;
         checked_count++;
         if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
               $display("%0t: norm_value mismatch, expected %0d, got %0d",
                        $realtime, want, got);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_norm.delete();
         pending_count = 0;
      end else begin
         if (req_tvalid && req_tready) take_request(req_tuser[0], req_tdata);
         if (rsp_tvalid && rsp_tready) check_result(rsp_tdata);
      end
   end

endmodule

// ----- verif/local_mean_subtract_normalize_tb.sv -----
// Testbench top for local_mean_subtract_normalize: loads two corner blocks of
// the frame, then sends directed and random pixel writes and reads with idling.
// Depends on lmsn_pkg, the block and local_mean_subtract_normalize_checker.
`timescale 1ns / 1ps

module local_mean_subtract_normalize_tb;

   localparam int WIDTH  = lmsn_pkg::WIDTH;
   localparam int HEIGHT = lmsn_pkg::HEIGHT;
   localparam int RADIUS = lmsn_pkg::RADIUS;
   localparam int COL_W  = lmsn_pkg::COL_W;
   localparam int ROW_W  = lmsn_pkg::ROW_W;
   localparam int PIX_W  = lmsn_pkg::PIX_W;

   localparam int RANDOM_ITEMS = 230;
   localparam int A_SIDE       = 16;   // top-left block
   localparam int B_SIDE       = 12;   // bottom-right block

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;   // col[6:0], row[13:7], pixel_in[21:14], zero fill
   logic [0:0]  req_tuser  = '0;   // func[0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // norm_value[7:0]

   bit calm = 1'b0;
   int items_sent = 0;
   int fail_count, pending_count, checked_count;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   local_mean_subtract_normalize dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   local_mean_subtract_normalize_checker norm_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .checked_count (checked_count)
   );

   always @(posedge clock) begin
      rsp_tready <= calm || ($urandom_range(99) >= 31);
   end

   task automatic send_item(input logic func, input logic [COL_W-1:0] c,
                            input logic [ROW_W-1:0] r, input logic [PIX_W-1:0] p);
      while (!calm && $urandom_range(99) < 31) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {2'b00, p, r, c};
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   initial begin
      logic [COL_W-1:0] c;
      logic [ROW_W-1:0] r;
      logic [PIX_W-1:0] p;
      int sel, fill_items, lo;
      bit hi;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // two corner blocks; a 9x9 patch and a clipped 5x5 patch saturate both ways
      for (int y = 0; y < A_SIDE; y++) begin
         for (int x = 0; x < A_SIDE; x++) begin
            if (x >= 2 && x <= 10 && y >= 2 && y <= 10)
               p = (x == 6 && y == 6) ? 8'hFF : 8'h00;
            else
               p = PIX_W'($urandom_range(255));
            send_item(lmsn_pkg::FUNC_WRITE, COL_W'(x), ROW_W'(y), p);
         end
      end
      for (int y = HEIGHT - B_SIDE; y < HEIGHT; y++) begin
         for (int x = WIDTH - B_SIDE; x < WIDTH; x++) begin
            if (x >= WIDTH - 5 && y >= HEIGHT - 5)
               p = (x == WIDTH - 1 && y == HEIGHT - 1) ? 8'h00 : 8'hFF;
            else
               p = PIX_W'($urandom_range(255));
            send_item(lmsn_pkg::FUNC_WRITE, COL_W'(x), ROW_W'(y), p);
         end
      end
      fill_items = items_sent;

      // directed
      send_item(lmsn_pkg::FUNC_READ,  7'd6,   7'd6,   8'hFF);
      send_item(lmsn_pkg::FUNC_READ,  7'd95,  7'd95,  8'h00);
      send_item(lmsn_pkg::FUNC_READ,  7'd0,   7'd0,   8'h5A);
      send_item(lmsn_pkg::FUNC_READ,  7'd95,  7'd88,  8'h00);
      send_item(lmsn_pkg::FUNC_READ,  7'd88,  7'd95,  8'hFF);
      send_item(lmsn_pkg::FUNC_READ,  7'd11,  7'd11,  8'h00);
      send_item(lmsn_pkg::FUNC_READ,  7'd0,   7'd11,  8'h00);
      send_item(lmsn_pkg::FUNC_READ,  7'd11,  7'd0,   8'h00);
      send_item(lmsn_pkg::FUNC_READ,  7'd88,  7'd88,  8'h00);
      send_item(lmsn_pkg::FUNC_READ,  7'd91,  7'd91,  8'h00);
      send_item(lmsn_pkg::FUNC_WRITE, 7'd127, 7'd127, 8'hFF);
      send_item(lmsn_pkg::FUNC_WRITE, 7'd96,  7'd5,   8'hAA);
      send_item(lmsn_pkg::FUNC_WRITE, 7'd5,   7'd96,  8'h55);
      send_item(lmsn_pkg::FUNC_READ,  7'd96,  7'd0,   8'h00);
      send_item(lmsn_pkg::FUNC_READ,  7'd0,   7'd96,  8'h00);
      send_item(lmsn_pkg::FUNC_READ,  7'd127, 7'd127, 8'hFF);
      send_item(lmsn_pkg::FUNC_WRITE, 7'd0,   7'd0,   8'hFF);
      send_item(lmsn_pkg::FUNC_READ,  7'd0,   7'd0,   8'h00);
      send_item(lmsn_pkg::FUNC_WRITE, 7'd95,  7'd95,  8'h00);
      send_item(lmsn_pkg::FUNC_READ,  7'd95,  7'd95,  8'h00);
      send_item(lmsn_pkg::FUNC_READ,  7'd5,   7'd5,   8'h00);

      // random mix inside the loaded blocks, with some off-frame items; a quiet stretch with no idling
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         calm = (n >= 80 && n < 150);
         sel = $urandom_range(99);
         hi = ($urandom_range(1) == 1);
         lo = (sel >= 50) ? RADIUS : 0;   // reads keep their window inside a block
         if (hi) begin
            c = COL_W'($urandom_range(WIDTH - 1, WIDTH - B_SIDE + lo));
            r = ROW_W'($urandom_range(HEIGHT - 1, HEIGHT - B_SIDE + lo));
         end else begin
            c = COL_W'($urandom_range(A_SIDE - 1 - lo));
            r = ROW_W'($urandom_range(A_SIDE - 1 - lo));
         end
         p = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 8'hFF : 8'h00)
                                      : PIX_W'($urandom_range(255));
         if (sel < 8) begin
            if ($urandom_range(1))
               c = COL_W'($urandom_range(127, WIDTH));
            else
               r = ROW_W'($urandom_range(127, HEIGHT));
            send_item($urandom_range(1) ? lmsn_pkg::FUNC_READ : lmsn_pkg::FUNC_WRITE,
                      c, r, p);
         end else if (sel < 50) begin
            send_item(lmsn_pkg::FUNC_WRITE, c, r, p);
         end else begin
            send_item(lmsn_pkg::FUNC_READ, c, r, p);
         end
      end
      calm = 1'b0;
      req_tvalid <= 1'b0;

      @(posedge clock);
      wait (pending_count == 0);
      repeat (150) @(posedge clock);

      $display("Two corner blocks of %0d pixels loaded, then %0d directed and random items sent.",
               fill_items, items_sent - fill_items);
      $display("%0d normalised pixels compared, %0d failures.", checked_count, fail_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #8_000_000;
      $display("Timed out with %0d results outstanding.", pending_count);
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
